@@ rtl/core/pct_pkg.sv @@
`default_nettype none

package pct_pkg;

    // Default CORDIC depth and the pre-scaled start vector (0.60725293500888 in Q2.30)
    localparam int PCT_CORDIC_STAGES = 16;
    localparam logic signed [31:0] PCT_GAIN_Q30 = 32'sd652032874;

    // One input beat
    typedef struct packed {
        logic               has_parent;
        logic signed [31:0] parent_x;
        logic signed [31:0] parent_y;
        logic signed [15:0] parent_scale_x;
        logic signed [15:0] parent_scale_y;
        logic        [15:0] parent_angle;
        logic signed [31:0] local_x;
        logic signed [31:0] local_y;
        logic signed [15:0] local_scale_x;
        logic signed [15:0] local_scale_y;
        logic        [15:0] local_angle;
    } t_in_beat;

    // One result beat
    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [15:0] world_scale_x;
        logic signed [15:0] world_scale_y;
        logic        [15:0] world_angle;
        logic               saturated;
    } t_out_beat;

    // Data handed from cell to cell along the rotator chain
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               flip;
        t_in_beat           item;
    } t_cordic;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] pct_atan(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pct_cordic_cell.sv @@
`default_nettype none

module pct_cordic_cell
    import pct_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_vld,
    input  wire t_cordic i_data,
    output logic         o_rdy,
    output logic         o_vld,
    output t_cordic      o_data,
    input  wire logic    i_rdy
);

    localparam logic signed [31:0] ATAN = $signed(pct_atan(5'(STAGE)));

    logic    r_vld;
    t_cordic r_data;
    t_cordic n_data;
    logic signed [31:0] xs;
    logic signed [31:0] ys;

    // Take a beat whenever this cell is empty or its content moves on
    assign o_rdy = !r_vld || i_rdy;

    // One micro-rotation, direction from the sign of the residual angle
    always_comb begin
        xs = $signed(i_data.x) >>> STAGE;
        ys = $signed(i_data.y) >>> STAGE;
        n_data = i_data;
        if (!i_data.z[31]) begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - ATAN;
        end else begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

`default_nettype wire

@@ rtl/core/pct_combine.sv @@
`default_nettype none

module pct_combine
    import pct_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_inherit,
    input  wire logic    i_vld,
    input  wire t_cordic i_data,
    output logic         o_rdy,
    output logic         o_vld,
    output t_out_beat    o_beat,
    input  wire logic    i_rdy
);

    // Clip a rounded position to the signed 32-bit range, flag in the top bit
    function automatic logic [32:0] clip32(input logic signed [36:0] v);
        logic [32:0] r;
        if (v > 37'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -37'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    // Round a Q16.16 scale product half up to Q8.8 and clip, flag in the top bit
    function automatic logic [16:0] scale_rnd(input logic signed [31:0] p);
        logic signed [32:0] s;
        logic signed [24:0] q;
        logic        [16:0] r;
        s = {p[31], p} + 33'sd128;
        q = s[32:8];
        if (q > 25'sd32767) begin
            r = {1'b1, 16'h7FFF};
        end else if (q < -25'sd32768) begin
            r = {1'b1, 16'h8000};
        end else begin
            r = {1'b0, q[15:0]};
        end
        return r;
    endfunction

    // Stage valids and ready chain
    logic r1_vld, r2_vld, r3_vld, r4_vld;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4  = !r4_vld || i_rdy;
    assign rdy3  = !r3_vld || rdy4;
    assign rdy2  = !r2_vld || rdy3;
    assign rdy1  = !r1_vld || rdy2;
    assign o_rdy = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (rdy1) r1_vld <= i_vld;
            if (rdy2) r2_vld <= r1_vld;
            if (rdy3) r3_vld <= r2_vld;
            if (rdy4) r4_vld <= r3_vld;
        end
    end

    // Stage 1: products
    logic signed [63:0] r1_pxc, r1_pys, r1_pxs, r1_pyc;
    logic signed [31:0] r1_psx, r1_psy;
    logic        [15:0] r1_wa;
    logic               r1_flip, r1_hp, r1_inh;
    logic signed [31:0] r1_px, r1_py, r1_lx, r1_ly;
    logic signed [15:0] r1_lsx, r1_lsy;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_pxc  <= $signed(i_data.item.local_x) * $signed(i_data.x);
            r1_pys  <= $signed(i_data.item.local_y) * $signed(i_data.y);
            r1_pxs  <= $signed(i_data.item.local_x) * $signed(i_data.y);
            r1_pyc  <= $signed(i_data.item.local_y) * $signed(i_data.x);
            r1_psx  <= $signed(i_data.item.parent_scale_x) * $signed(i_data.item.local_scale_x);
            r1_psy  <= $signed(i_data.item.parent_scale_y) * $signed(i_data.item.local_scale_y);
            r1_wa   <= i_data.item.has_parent
                     ? i_data.item.parent_angle + i_data.item.local_angle
                     : i_data.item.local_angle;
            r1_flip <= i_data.flip;
            r1_hp   <= i_data.item.has_parent;
            r1_inh  <= i_inherit;
            r1_px   <= i_data.item.parent_x;
            r1_py   <= i_data.item.parent_y;
            r1_lx   <= i_data.item.local_x;
            r1_ly   <= i_data.item.local_y;
            r1_lsx  <= i_data.item.local_scale_x;
            r1_lsy  <= i_data.item.local_scale_y;
        end
    end

    // Stage 2: rotated offsets, scale rounding and choice
    logic signed [64:0] r2_dx, r2_dy;
    logic signed [15:0] r2_wsx, r2_wsy;
    logic               r2_ssat, r2_flip, r2_hp;
    logic        [15:0] r2_wa;
    logic signed [31:0] r2_px, r2_py, r2_lx, r2_ly;
    logic        [16:0] sx_rnd, sy_rnd;
    logic               use_scale;

    always_comb begin
        sx_rnd    = scale_rnd(r1_psx);
        sy_rnd    = scale_rnd(r1_psy);
        use_scale = r1_hp && r1_inh;
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_dx   <= {r1_pxc[63], r1_pxc} - {r1_pys[63], r1_pys};
            r2_dy   <= {r1_pxs[63], r1_pxs} + {r1_pyc[63], r1_pyc};
            r2_wsx  <= use_scale ? $signed(sx_rnd[15:0]) : r1_lsx;
            r2_wsy  <= use_scale ? $signed(sy_rnd[15:0]) : r1_lsy;
            r2_ssat <= use_scale && (sx_rnd[16] || sy_rnd[16]);
            r2_flip <= r1_flip;
            r2_hp   <= r1_hp;
            r2_wa   <= r1_wa;
            r2_px   <= r1_px;
            r2_py   <= r1_py;
            r2_lx   <= r1_lx;
            r2_ly   <= r1_ly;
        end
    end

    // Stage 3: add parent position, apply half-turn negation, add rounding bias
    logic signed [66:0] r3_ax, r3_ay;
    logic signed [15:0] r3_wsx, r3_wsy;
    logic               r3_ssat, r3_hp;
    logic        [15:0] r3_wa;
    logic signed [31:0] r3_lx, r3_ly;
    logic signed [66:0] dx_ext, dy_ext, px_ext, py_ext;

    always_comb begin
        dx_ext = {{2{r2_dx[64]}}, r2_dx};
        dy_ext = {{2{r2_dy[64]}}, r2_dy};
        if (r2_flip) begin
            dx_ext = -dx_ext;
            dy_ext = -dy_ext;
        end
        px_ext = {{5{r2_px[31]}}, r2_px, 30'b0};
        py_ext = {{5{r2_py[31]}}, r2_py, 30'b0};
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_ax   <= px_ext + dx_ext + 67'sd536870912;
            r3_ay   <= py_ext + dy_ext + 67'sd536870912;
            r3_wsx  <= r2_wsx;
            r3_wsy  <= r2_wsy;
            r3_ssat <= r2_ssat;
            r3_hp   <= r2_hp;
            r3_wa   <= r2_wa;
            r3_lx   <= r2_lx;
            r3_ly   <= r2_ly;
        end
    end

    // Stage 4: drop the fraction, clip, hold the result beat
    t_out_beat   r4_beat;
    t_out_beat   n4_beat;
    logic [32:0] wx_clip, wy_clip;

    always_comb begin
        wx_clip = clip32(r3_ax[66:30]);
        wy_clip = clip32(r3_ay[66:30]);
        n4_beat.world_x       = r3_hp ? $signed(wx_clip[31:0]) : r3_lx;
        n4_beat.world_y       = r3_hp ? $signed(wy_clip[31:0]) : r3_ly;
        n4_beat.world_scale_x = r3_wsx;
        n4_beat.world_scale_y = r3_wsy;
        n4_beat.world_angle   = r3_wa;
        n4_beat.saturated     = r3_ssat || (r3_hp && (wx_clip[32] || wy_clip[32]));
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_beat <= n4_beat;
        end
    end

    assign o_vld  = r4_vld;
    assign o_beat = r4_beat;

endmodule

`default_nettype wire

@@ rtl/core/planar_transform_compose.sv @@
// Each accepted input beat passes through the rotator cells, then the combine stages.
// Throughput: one beat per cycle while the output accepts; each rotator cell and each combine
// stage holds one beat and takes a new one whenever it is empty or its own beat moves on.
// Reset (synchronous, active low): clears every stage valid and inherit_scale;
// pipeline data registers are not reset.
`default_nettype none

module planar_transform_compose
    import pct_pkg::*;
#(
    parameter int CORDIC_STAGES = PCT_CORDIC_STAGES
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_beat i_in_beat,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_beat     o_out_beat
);

    logic    r_inherit_scale;
    t_cordic w_data [0:CORDIC_STAGES];
    logic    w_vld  [0:CORDIC_STAGES];
    logic    w_rdy  [0:CORDIC_STAGES];

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inherit_scale <= 1'b0;
        end else if (i_cfg_we) begin
            r_inherit_scale <= i_cfg_wdata;
        end
    end

    // Fold the parent angle into the right half-plane and seed the rotator
    always_comb begin
        w_data[0].flip = i_in_beat.parent_angle[15] ^ i_in_beat.parent_angle[14];
        w_data[0].x    = PCT_GAIN_Q30;
        w_data[0].y    = 32'sd0;
        w_data[0].z    = {i_in_beat.parent_angle[15] ^ w_data[0].flip,
                          i_in_beat.parent_angle[14:0], 16'b0};
        w_data[0].item = i_in_beat;
    end

    assign w_vld[0]   = i_in_valid;
    assign o_in_ready = w_rdy[0];

    // Rotator chain
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        pct_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .i_data  (w_data[g]),
            .o_rdy   (w_rdy[g]),
            .o_vld   (w_vld[g+1]),
            .o_data  (w_data[g+1]),
            .i_rdy   (w_rdy[g+1])
        );
    end

    // Products, sums, rounding and clipping
    pct_combine u_combine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_inherit (r_inherit_scale),
        .i_vld     (w_vld[CORDIC_STAGES]),
        .i_data    (w_data[CORDIC_STAGES]),
        .o_rdy     (w_rdy[CORDIC_STAGES]),
        .o_vld     (o_out_valid),
        .o_beat    (o_out_beat),
        .i_rdy     (i_out_ready)
    );

    // Input back-pressure only arises from a result beat held at the output
    a_ready_low_only_when_blocked: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready)
    ) else $error("input stalled while output not blocked");

    // No result beat straight out of reset
    a_empty_after_reset: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid
    ) else $error("result beat valid right after reset");

    // A free output register never holds back the last rotator cell
    a_tail_flows: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> w_rdy[CORDIC_STAGES]
    ) else $error("combine stage stalled with free output");

endmodule

`default_nettype wire
